>>> src/ptfue_pkg.sv
// ptfue_pkg: shared types, constants and character helpers for the path to
// file URL encoder. No dependencies.
package ptfue_pkg;

  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  localparam logic [7:0] ByteSlash = 8'h2F;
  localparam logic [6:0] CharPct   = 7'h25;
  localparam logic [6:0] CharNul   = 7'h00;
  localparam logic [2:0] PfxLastIdx = 3'd6;

  localparam logic [5:0] SurHighTag = 6'b110110;
  localparam logic [5:0] SurLowTag  = 6'b110111;
  localparam logic [20:0] SuppBase  = 21'h10000;

  // one unit of work for the back end
  typedef struct packed {
    logic        fail;   // emit the single failure item
    logic        pfx;    // emit "file://" first
    logic        last;   // final item of the URL closes this job
    logic [20:0] cp;     // code point to encode
  } job_t;

  function automatic logic is_passthrough(logic [6:0] c);
    logic r;
    r = ((c >= 7'h30) && (c <= 7'h39)) || ((c >= 7'h41) && (c <= 7'h5A)) ||
        ((c >= 7'h61) && (c <= 7'h7A));
    case (c)
      7'h2D, 7'h2E, 7'h5F, 7'h7E, 7'h3A, 7'h26, 7'h3D, 7'h3B, 7'h2F: r = 1'b1;
      default: ;
    endcase
    return r;
  endfunction

  function automatic logic [6:0] hex_char(logic [3:0] n);
    logic [6:0] r;
    if (n < 4'd10) begin
      r = 7'h30 + {3'b000, n};
    end else begin
      r = 7'h37 + {3'b000, n};
    end
    return r;
  endfunction

  function automatic logic [6:0] prefix_char(logic [2:0] i);
    logic [6:0] r;
    case (i)
      3'd0: r = 7'h66;  // f
      3'd1: r = 7'h69;  // i
      3'd2: r = 7'h6C;  // l
      3'd3: r = 7'h65;  // e
      3'd4: r = 7'h3A;  // :
      default: r = 7'h2F;  // /
    endcase
    return r;
  endfunction

endpackage

>>> src/ptfue_front.sv
// ptfue_front: accepts CESU-8 bytes, decodes units and surrogate pairs and
// pushes one job per byte that yields output. Depends on ptfue_pkg.
module ptfue_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [7:0]        in_byte_i,
  input  logic              in_end_i,
  input  logic              q_full_i,
  output logic              q_push_o,
  output ptfue_pkg::job_t   q_job_o
);

  logic        at_start_q, at_start_d;
  logic [1:0]  pend_q, pend_d;
  logic [15:0] accum_q, accum_d;
  logic [9:0]  held_q, held_d;
  logic        hs_valid_q, hs_valid_d;
  logic        drop_q, drop_d;

  logic        accept;
  logic        fail, pfx, emit, fin;
  logic [15:0] unit, acc_new;
  logic [1:0]  pend_new;
  logic [20:0] cp;

  assign in_ready_o = ~q_full_i;
  assign accept     = in_valid_i & ~q_full_i;

  always_comb begin
    at_start_d = at_start_q;
    pend_d     = pend_q;
    accum_d    = accum_q;
    held_d     = held_q;
    hs_valid_d = hs_valid_q;
    drop_d     = drop_q;
    fail       = 1'b0;
    pfx        = 1'b0;
    emit       = 1'b0;
    fin        = 1'b0;
    unit       = {8'h00, in_byte_i};
    acc_new    = {accum_q[9:0], in_byte_i[5:0]};
    pend_new   = pend_q - 2'd1;
    cp         = {5'd0, unit};

    if (drop_q) begin
      if (in_end_i) begin
        at_start_d = 1'b1;
        drop_d     = 1'b0;
      end
    end else begin
      if (at_start_q) begin
        at_start_d = 1'b0;
        if (in_byte_i != ptfue_pkg::ByteSlash) begin
          fail = 1'b1;
        end else begin
          pfx = 1'b1;
          fin = 1'b1;
        end
      end else if (pend_q == 2'd0) begin
        if (!in_byte_i[7]) begin
          fin = 1'b1;
        end else if (in_byte_i[7:5] == 3'b110) begin
          accum_d = {11'd0, in_byte_i[4:0]};
          pend_d  = 2'd1;
        end else if (in_byte_i[7:4] == 4'b1110) begin
          accum_d = {12'd0, in_byte_i[3:0]};
          pend_d  = 2'd2;
        end else begin
          fail = 1'b1;
        end
      end else begin
        if (in_byte_i[7:6] != 2'b10) begin
          fail = 1'b1;
        end else begin
          pend_d = pend_new;
          if (pend_new == 2'd0) begin
            accum_d = '0;
            unit    = acc_new;
            fin     = 1'b1;
          end else begin
            accum_d = acc_new;
          end
        end
      end

      cp = {5'd0, unit};
      if (fin) begin
        if (hs_valid_q) begin
          if (unit[15:10] != ptfue_pkg::SurLowTag) begin
            fail = 1'b1;
          end else begin
            cp         = ptfue_pkg::SuppBase + {1'b0, held_q, unit[9:0]};
            hs_valid_d = 1'b0;
            held_d     = '0;
            emit       = 1'b1;
          end
        end else if (unit[15:10] == ptfue_pkg::SurLowTag) begin
          fail = 1'b1;
        end else if (unit[15:10] == ptfue_pkg::SurHighTag) begin
          held_d     = unit[9:0];
          hs_valid_d = 1'b1;
        end else begin
          emit = 1'b1;
        end
      end

      if (!fail && in_end_i && ((pend_d != 2'd0) || hs_valid_d)) begin
        fail = 1'b1;
      end

      if (fail || in_end_i) begin
        at_start_d = 1'b1;
        pend_d     = '0;
        accum_d    = '0;
        held_d     = '0;
        hs_valid_d = 1'b0;
        drop_d     = fail & ~in_end_i;
      end
    end
  end

  assign q_push_o     = accept & ~drop_q & (fail | pfx | emit);
  assign q_job_o.fail = fail;
  assign q_job_o.pfx  = pfx & ~fail;
  assign q_job_o.last = in_end_i | fail;
  assign q_job_o.cp   = cp;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      at_start_q <= 1'b1;
      pend_q     <= '0;
      accum_q    <= '0;
      held_q     <= '0;
      hs_valid_q <= 1'b0;
      drop_q     <= 1'b0;
    end else if (accept) begin
      at_start_q <= at_start_d;
      pend_q     <= pend_d;
      accum_q    <= accum_d;
      held_q     <= held_d;
      hs_valid_q <= hs_valid_d;
      drop_q     <= drop_d;
    end
  end

endmodule

>>> src/ptfue_fifo.sv
// ptfue_fifo: short job queue between front and back end.
// Depends on ptfue_pkg for the job type and depth.
module ptfue_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  ptfue_pkg::job_t wdata_i,
  output logic            full_o,
  input  logic            pop_i,
  output ptfue_pkg::job_t rdata_o,
  output logic            empty_o
);

  localparam logic [ptfue_pkg::QCntW-1:0] DepthCnt = ptfue_pkg::QCntW'(ptfue_pkg::QDepth);
  localparam logic [ptfue_pkg::QPtrW-1:0] LastPtr  = ptfue_pkg::QPtrW'(ptfue_pkg::QDepth - 1);

  ptfue_pkg::job_t mem_q [ptfue_pkg::QDepth];
  logic [ptfue_pkg::QPtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [ptfue_pkg::QCntW-1:0] cnt_q, cnt_d;
  logic do_push, do_pop;

  assign full_o  = (cnt_q == DepthCnt);
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign rdata_o = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == LastPtr) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == LastPtr) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

>>> src/ptfue_back.sv
// ptfue_back: expands each job into URL characters, one per cycle while the
// output is not stalled, into a registered output stage. Depends on ptfue_pkg.
module ptfue_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            q_empty_i,
  input  ptfue_pkg::job_t q_job_i,
  output logic            q_pop_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [6:0]      out_char_o,
  output logic            out_last_o,
  output logic            out_failed_o
);

  ptfue_pkg::job_t job_q;
  logic       job_valid_q, job_valid_d;
  logic       in_pfx_q, in_pfx_d;
  logic [2:0] pidx_q, pidx_d;
  logic [1:0] bidx_q, bidx_d;
  logic [1:0] dig_q, dig_d;

  logic       out_valid_q, out_valid_d;
  logic [6:0] out_char_q;
  logic       out_last_q, out_failed_q;

  logic [1:0] nb_last;
  logic [7:0] ub [4];
  logic [7:0] cur;
  logic       plain, fire, final_c, load;
  logic [6:0] ch;

  always_comb begin
    ub[0] = {1'b0, job_q.cp[6:0]};
    ub[1] = 8'h00;
    ub[2] = 8'h00;
    ub[3] = 8'h00;
    if (job_q.cp < 21'h80) begin
      nb_last = 2'd0;
    end else if (job_q.cp < 21'h800) begin
      nb_last = 2'd1;
      ub[0] = {3'b110, job_q.cp[10:6]};
      ub[1] = {2'b10, job_q.cp[5:0]};
    end else if (job_q.cp < 21'h10000) begin
      nb_last = 2'd2;
      ub[0] = {4'b1110, job_q.cp[15:12]};
      ub[1] = {2'b10, job_q.cp[11:6]};
      ub[2] = {2'b10, job_q.cp[5:0]};
    end else begin
      nb_last = 2'd3;
      ub[0] = {5'b11110, job_q.cp[20:18]};
      ub[1] = {2'b10, job_q.cp[17:12]};
      ub[2] = {2'b10, job_q.cp[11:6]};
      ub[3] = {2'b10, job_q.cp[5:0]};
    end
  end

  assign cur   = ub[bidx_q];
  assign plain = (nb_last == 2'd0) & ptfue_pkg::is_passthrough(job_q.cp[6:0]);

  always_comb begin
    ch      = ptfue_pkg::CharNul;
    final_c = 1'b0;
    if (job_q.fail) begin
      final_c = 1'b1;
    end else if (in_pfx_q) begin
      ch = ptfue_pkg::prefix_char(pidx_q);
    end else if (plain) begin
      ch      = job_q.cp[6:0];
      final_c = 1'b1;
    end else begin
      case (dig_q)
        2'd0:    ch = ptfue_pkg::CharPct;
        2'd1:    ch = ptfue_pkg::hex_char(cur[7:4]);
        default: ch = ptfue_pkg::hex_char(cur[3:0]);
      endcase
      final_c = (dig_q == 2'd2) && (bidx_q == nb_last);
    end
  end

  assign fire    = job_valid_q & (~out_valid_q | out_ready_i);
  assign load    = ~q_empty_i & (~job_valid_q | (fire & final_c));
  assign q_pop_o = load;

  always_comb begin
    job_valid_d = job_valid_q;
    in_pfx_d    = in_pfx_q;
    pidx_d      = pidx_q;
    bidx_d      = bidx_q;
    dig_d       = dig_q;
    if (fire) begin
      if (final_c) begin
        job_valid_d = 1'b0;
      end else if (in_pfx_q) begin
        pidx_d = pidx_q + 3'd1;
        if (pidx_q == ptfue_pkg::PfxLastIdx) begin
          in_pfx_d = 1'b0;
        end
      end else if (dig_q == 2'd2) begin
        dig_d  = 2'd0;
        bidx_d = bidx_q + 2'd1;
      end else begin
        dig_d = dig_q + 2'd1;
      end
    end
    if (load) begin
      job_valid_d = 1'b1;
      in_pfx_d    = q_job_i.pfx;
      pidx_d      = '0;
      bidx_d      = '0;
      dig_d       = '0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (fire) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      job_q <= q_job_i;
    end
    if (fire) begin
      out_char_q   <= ch;
      out_last_q   <= final_c & job_q.last;
      out_failed_q <= job_q.fail;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      job_valid_q <= 1'b0;
      in_pfx_q    <= 1'b0;
      pidx_q      <= '0;
      bidx_q      <= '0;
      dig_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      job_valid_q <= job_valid_d;
      in_pfx_q    <= in_pfx_d;
      pidx_q      <= pidx_d;
      bidx_q      <= bidx_d;
      dig_q       <= dig_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_char_o   = out_char_q;
  assign out_last_o   = out_last_q;
  assign out_failed_o = out_failed_q;

endmodule

>>> src/path_to_file_url_encoder.sv
// path_to_file_url_encoder: top level; front decoder, job queue and character
// sequencer. Depends on ptfue_pkg, ptfue_front, ptfue_fifo, ptfue_back.
//
// Takes an absolute path as CESU-8 bytes on the slave stream (tlast marks the
// final byte) and streams the file URL out one ASCII character per item:
// "file://" on the first byte, then each character either passed through or
// written as %XX in UTF-8. A bad path gives one item with tuser (failed) and
// tlast set, after which bytes are dropped up to the path's tlast. The front
// end takes one byte per cycle while the queue is not full. Output runs at one
// character per cycle from the back-end sequencer while m_axis_tready is high;
// a byte yields no characters for a lead or middle byte or a held high
// surrogate, 1 for a plain character or the failure item, 3 per UTF-8 byte
// otherwise, up to 9 for a three-byte unit, 12 for a surrogate pair and 8 for
// the leading '/'. A two-entry job queue lets input bytes be taken while
// earlier characters are still going out; output stalls reach the input only
// once the queue fills.
module path_to_file_url_encoder (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
  input  logic       s_axis_tlast,   // end_of_path
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [6:0] out_char, [7] zero
  output logic       m_axis_tlast,   // out_last
  output logic       m_axis_tuser    // failed
);

  logic            q_full, q_empty, q_push, q_pop;
  ptfue_pkg::job_t q_wjob, q_rjob;
  logic [6:0]      out_char;

  ptfue_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_byte_i  (s_axis_tdata),
    .in_end_i   (s_axis_tlast),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_job_o    (q_wjob)
  );

  ptfue_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .wdata_i (q_wjob),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .rdata_o (q_rjob),
    .empty_o (q_empty)
  );

  ptfue_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_empty_i    (q_empty),
    .q_job_i      (q_rjob),
    .q_pop_o      (q_pop),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_char_o   (out_char),
    .out_last_o   (m_axis_tlast),
    .out_failed_o (m_axis_tuser)
  );

  assign m_axis_tdata = {1'b0, out_char};

endmodule
